// ----- rtl/core/lfb_pkg.sv -----
// Shared widths, register indexes and types for the linear distance fog blend.
package lfb_pkg;

	localparam int DIST_SQ_WIDTH = 48;

	// Square root: two result digits per pipeline stage
	localparam int ROOT_W = 2 * ((DIST_SQ_WIDTH + 3) / 4);
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int DIGITS_PER_STAGE = 2;
	localparam int SQ_STAGES = ROOT_W / DIGITS_PER_STAGE;

	localparam int COLOR_W = 24;
	localparam int CH_W = 8;
	localparam int FACTOR_W = 8;
	localparam int CFG_W = 24;
	localparam int NEAR_W = 24;
	localparam int SLOPE_W = 24;
	localparam int FRAC_W = 24;
	localparam int X_W = ROOT_W + SLOPE_W;
	localparam int CMP_W = (ROOT_W > NEAR_W) ? ROOT_W : NEAR_W;
	localparam int BLEND_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FOG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_DISTANCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DENSITY_SLOPE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOG_COLOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;

	localparam logic FMT_RGB565 = 1'b1;
	localparam logic [FACTOR_W-1:0] FACTOR_MAX = 8'd255;
	localparam logic [X_W-1:0] CLAMP_X = X_W'(FACTOR_MAX) << FRAC_W;
	localparam logic [BLEND_W-1:0] BLEND_ROUND = 16'd127;

	typedef struct packed {
		logic fog_enable;
		logic [NEAR_W-1:0] near_distance;
		logic [SLOPE_W-1:0] density_slope;
		logic [COLOR_W-1:0] fog_color;
		logic pixel_format;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [FACTOR_W-1:0] factor;
	} result_t;

endpackage

// ----- rtl/core/lfb_isqrt.sv -----
// Pipelined integer square root, two result digits per stage, with a color tag alongside.
module lfb_isqrt import lfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic [RAD_W-1:0] rad,
	input logic [COLOR_W-1:0] tag_in,
	output logic out_valid,
	output logic [ROOT_W-1:0] root,
	output logic [COLOR_W-1:0] tag_out
);

	logic [SQ_STAGES-1:0] valid_s;
	logic [ROOT_W-1:0] root_s [SQ_STAGES];
	logic [COLOR_W-1:0] tag_s [SQ_STAGES];
	logic [REM_W-1:0] rem_s [SQ_STAGES-1];
	logic [RAD_W-1:0] rad_s [SQ_STAGES-1];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		logic prev_valid;
		logic [REM_W-1:0] prev_rem;
		logic [ROOT_W-1:0] prev_root;
		logic [RAD_W-1:0] prev_rad;
		logic [COLOR_W-1:0] prev_tag;
		logic [REM_W-1:0] rem_nxt;
		logic [ROOT_W-1:0] root_nxt;

		if (k == 0) begin : g_first
			assign prev_valid = in_valid;
			assign prev_rem = '0;
			assign prev_root = '0;
			assign prev_rad = rad;
			assign prev_tag = tag_in;
		end else begin : g_next
			assign prev_valid = valid_s[k-1];
			assign prev_rem = rem_s[k-1];
			assign prev_root = root_s[k-1];
			assign prev_rad = rad_s[k-1];
			assign prev_tag = tag_s[k-1];
		end

		// restoring digit recurrence: bring down two radicand bits, try root*4+1
		always_comb begin
			logic [REM_W-1:0] rem_sh;
			logic [REM_W-1:0] trial;
			rem_nxt = prev_rem;
			root_nxt = prev_root;
			for (int j = 0; j < DIGITS_PER_STAGE; j++) begin
				rem_sh = {rem_nxt[ROOT_W-1:0], prev_rad[RAD_W-1-2*j -: 2]};
				trial = {root_nxt, 2'b01};
				if (rem_sh >= trial) begin
					rem_nxt = rem_sh - trial;
					root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
				end else begin
					rem_nxt = rem_sh;
					root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s[k] <= root_nxt;
				tag_s[k] <= prev_tag;
			end
		end

		if (k < SQ_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k] <= rem_nxt;
					rad_s[k] <= prev_rad << (2 * DIGITS_PER_STAGE);
				end
			end
		end
	end

	assign out_valid = valid_s[SQ_STAGES-1];
	assign root = root_s[SQ_STAGES-1];
	assign tag_out = tag_s[SQ_STAGES-1];

endmodule

// ----- rtl/core/lfb_factor.sv -----
// Fog factor stages: distance past near, slope multiply, clamp and ceiling.
module lfb_factor import lfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input cfg_t cfg,
	input logic in_valid,
	input logic [ROOT_W-1:0] root,
	input logic [COLOR_W-1:0] color_in,
	output logic out_valid,
	output logic [FACTOR_W-1:0] factor,
	output logic [COLOR_W-1:0] color_out
);

	logic valid_s1, valid_s2, valid_s3;
	logic [ROOT_W-1:0] d_s1;
	logic [X_W-1:0] x_s2;
	logic [FACTOR_W-1:0] f_s3;
	logic [COLOR_W-1:0] col_s1, col_s2, col_s3;

	logic [CMP_W-1:0] root_ext, near_ext;
	logic [ROOT_W-1:0] d_nxt;
	logic over;
	logic [FACTOR_W-1:0] ceil_x;
	logic [FACTOR_W-1:0] f_nxt;

	// at or inside near the distance past near is zero, which yields a full factor
	always_comb begin
		root_ext = CMP_W'(root);
		near_ext = CMP_W'(cfg.near_distance);
		if (root_ext > near_ext) begin
			d_nxt = ROOT_W'(root_ext - near_ext);
		end else begin
			d_nxt = '0;
		end
	end

	always_comb begin
		over = x_s2 > CLAMP_X;
		ceil_x = x_s2[FRAC_W +: FACTOR_W] + FACTOR_W'(|x_s2[FRAC_W-1:0]);
		if (!cfg.fog_enable) begin
			f_nxt = FACTOR_MAX;
		end else if (over) begin
			f_nxt = '0;
		end else begin
			f_nxt = FACTOR_MAX - ceil_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= d_nxt;
			col_s1 <= color_in;
			x_s2 <= {{SLOPE_W{1'b0}}, d_s1} * {{ROOT_W{1'b0}}, cfg.density_slope};
			col_s2 <= col_s1;
			f_s3 <= f_nxt;
			col_s3 <= col_s2;
		end
	end

	assign out_valid = valid_s3;
	assign factor = f_s3;
	assign color_out = col_s3;

endmodule

// ----- rtl/core/lfb_blend.sv -----
// Color blend stages: unpack, weighted sum, divide by 255 with rounding, repack.
module lfb_blend import lfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input cfg_t cfg,
	input logic in_valid,
	input logic [FACTOR_W-1:0] factor,
	input logic [COLOR_W-1:0] color_in,
	output logic out_valid,
	output result_t result
);

	logic valid_s1, valid_s2;
	logic [BLEND_W-1:0] t_s1 [3];
	logic [FACTOR_W-1:0] f_s1;
	logic [15:0] src_s1;
	result_t res_s2;

	logic [CH_W-1:0] src_ch [3];
	logic [CH_W-1:0] fog_ch [3];
	logic [BLEND_W-1:0] t_nxt [3];
	logic [CH_W-1:0] q [3];
	logic [COLOR_W-1:0] col_nxt;

	always_comb begin
		if (cfg.pixel_format == FMT_RGB565) begin
			// widen 5/6-bit fields by replicating their top bits
			src_ch[0] = {color_in[15:11], color_in[15:13]};
			src_ch[1] = {color_in[10:5], color_in[10:9]};
			src_ch[2] = {color_in[4:0], color_in[4:2]};
		end else begin
			src_ch[0] = color_in[23:16];
			src_ch[1] = color_in[15:8];
			src_ch[2] = color_in[7:0];
		end
		fog_ch[0] = cfg.fog_color[23:16];
		fog_ch[1] = cfg.fog_color[15:8];
		fog_ch[2] = cfg.fog_color[7:0];
		for (int i = 0; i < 3; i++) begin
			t_nxt[i] = BLEND_W'(factor) * BLEND_W'(src_ch[i])
				+ BLEND_W'(FACTOR_MAX - factor) * BLEND_W'(fog_ch[i]) + BLEND_ROUND;
		end
	end

	// t / 255 as (t + 1 + (t >> 8)) >> 8, exact over the blend range
	always_comb begin
		logic [BLEND_W:0] sum;
		for (int i = 0; i < 3; i++) begin
			sum = (BLEND_W + 1)'(t_s1[i]) + (BLEND_W + 1)'(1)
				+ (BLEND_W + 1)'(t_s1[i] >> 8);
			q[i] = sum[15:8];
		end
		if (cfg.pixel_format == FMT_RGB565) begin
			if (f_s1 == FACTOR_MAX) begin
				col_nxt = {8'b0, src_s1};
			end else begin
				col_nxt = {8'b0, q[0][7:3], q[1][7:2], q[2][7:3]};
			end
		end else begin
			col_nxt = {q[0], q[1], q[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= t_nxt;
			f_s1 <= factor;
			src_s1 <= color_in[15:0];
			res_s2.color <= col_nxt;
			res_s2.factor <= f_s1;
		end
	end

	assign out_valid = valid_s2;
	assign result = res_s2;

endmodule

// ----- rtl/core/lfb_outbuf.sv -----
// Output register with a one-beat skid entry; its fill state gates the pipeline.
module lfb_outbuf import lfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pipe_valid,
	input result_t pipe_data,
	output logic adv,
	output logic out_valid,
	input logic out_ready,
	output result_t out_data
);

	logic out_valid_q, skid_valid_q;
	result_t out_data_q, skid_data_q;
	logic arrive, open;

	assign adv = !skid_valid_q;
	assign arrive = adv && pipe_valid;
	assign open = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (open) begin
			out_valid_q <= skid_valid_q || arrive;
			skid_valid_q <= 1'b0;
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (open) begin
			out_data_q <= skid_valid_q ? skid_data_q : pipe_data;
		end else if (arrive) begin
			skid_data_q <= pipe_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a beat while the output register is empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		arrive && out_valid_q && !out_ready |=> skid_valid_q && out_valid_q)
		else $error("beat arriving at a stalled output was not parked");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> !skid_valid_q && out_valid_q)
		else $error("skid entry did not move to the output register");

endmodule

// ----- rtl/core/linear_distance_fog_blend.sv -----
// Linear distance fog blend: top level with configuration registers and pipeline.
//
// Input channel (in_valid/in_ready): one pixel per beat, dist_sq as unsigned
// Q32.16 squared eye distance and src_color as RGB888 or RGB565 (low 16 bits).
// Output channel (out_valid/out_ready): fogged_color in the source format and
// the 8-bit fog_factor (255 = no fog, 0 = pure fog color).
// Configuration: cfg_we writes cfg_data to the register at cfg_index in the
// same clock (fog_enable, near_distance, density_slope, fog_color,
// pixel_format). Write only while no pixel is in flight.
// Throughput: one pixel per clock while the output is not stalled. Pipeline:
// the square root (two digits per stage), then three factor stages, two
// blend stages and the output register.
// Reset: all configuration registers clear (fog off, RGB888) and every valid
// bit drops; the block accepts beats right after reset.
// Stall: a beat that meets a stalled output parks in a one-entry skid buffer,
// then in_ready drops and the whole pipeline holds until the output drains.
module linear_distance_fog_blend import lfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [DIST_SQ_WIDTH-1:0] dist_sq,
	input logic [COLOR_W-1:0] src_color,
	output logic out_valid,
	input logic out_ready,
	output logic [COLOR_W-1:0] fogged_color,
	output logic [FACTOR_W-1:0] fog_factor,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic adv;
	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	logic [COLOR_W-1:0] sq_color;
	logic fac_valid;
	logic [FACTOR_W-1:0] fac_factor;
	logic [COLOR_W-1:0] fac_color;
	logic bl_valid;
	result_t bl_result;
	result_t out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOG_ENABLE: cfg_q.fog_enable <= cfg_data[0];
				REG_NEAR_DISTANCE: cfg_q.near_distance <= cfg_data[NEAR_W-1:0];
				REG_DENSITY_SLOPE: cfg_q.density_slope <= cfg_data[SLOPE_W-1:0];
				REG_FOG_COLOR: cfg_q.fog_color <= cfg_data[COLOR_W-1:0];
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = adv;

	lfb_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(in_valid),
		.rad(RAD_W'(dist_sq)),
		.tag_in(src_color),
		.out_valid(sq_valid),
		.root(sq_root),
		.tag_out(sq_color)
	);

	lfb_factor u_factor (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cfg(cfg_q),
		.in_valid(sq_valid),
		.root(sq_root),
		.color_in(sq_color),
		.out_valid(fac_valid),
		.factor(fac_factor),
		.color_out(fac_color)
	);

	lfb_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cfg(cfg_q),
		.in_valid(fac_valid),
		.factor(fac_factor),
		.color_in(fac_color),
		.out_valid(bl_valid),
		.result(bl_result)
	);

	lfb_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.pipe_valid(bl_valid),
		.pipe_data(bl_result),
		.adv(adv),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	assign fogged_color = out_data.color;
	assign fog_factor = out_data.factor;

endmodule
